// File: sv/event_hash_table_engine_defines.svh
// Assertion macros used by the checker file.
`ifndef EVENT_HASH_TABLE_ENGINE_DEFINES_SVH
`define EVENT_HASH_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define EHTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("event hash table engine: check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define EHTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("event hash table engine: check failed");

`endif

// File: sv/ehte_pkg.sv
package ehte_pkg;

  localparam int MAX_EVENTS  = 64;
  localparam int HASH_MODULUS = 128;

  localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int RES_W = 7;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;

  localparam logic [7:0] OPC_WILDCARD = 8'hff;
  localparam logic [7:0] OPC_EMPTY    = 8'hff;
  localparam logic [2:0] HASH_MULT    = 3'd7;

  // Request codes carried on in_tuser.
  localparam logic [2:0] REQ_LOOKUP  = 3'd0;
  localparam logic [2:0] REQ_LEARN   = 3'd1;
  localparam logic [2:0] REQ_UNLEARN = 3'd2;
  localparam logic [2:0] REQ_CLEAR   = 3'd3;
  localparam logic [2:0] REQ_FIND    = 3'd4;
  localparam logic [2:0] REQ_COUNT   = 3'd5;
  localparam logic [2:0] REQ_READ    = 3'd6;

  typedef logic [7:0] mod_tab_t [256];

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'(i % HASH_MODULUS);
    end
    return t;
  endfunction

  // Reduction of the 8-bit raw hash into the hash range.
  localparam mod_tab_t HASH_MOD_TAB = build_mod_tab();

  function automatic logic [7:0] event_hash(input logic [15:0] nn, input logic [15:0] en);
    logic [7:0]  h1;
    logic [7:0]  e1;
    logic [10:0] prod;
    logic [7:0]  raw;
    h1   = nn[7:0] ^ nn[15:8];
    e1   = en[7:0] ^ en[15:8];
    prod = h1 * HASH_MULT;
    raw  = prod[7:0] + e1;
    return HASH_MOD_TAB[raw];
  endfunction

  typedef struct packed {
    logic load;       // latch a new request
    logic rd_en;      // read the table
    logic rd_scan;    // read address comes from the scan counter
    logic scan_clr;   // restart counter, tally and first-hit record
    logic wr_en;      // learn or unlearn write at the request index
    logic clr_all;    // drop every entry
    logic res_load;   // move the result into the output register
  } ehte_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       scan_last;
    logic       out_free;
  } ehte_sts_t;

endpackage

// File: sv/ehte_ctrl.sv
module ehte_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ehte_pkg::ehte_sts_t sts,
  output ehte_pkg::ehte_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req) inside
          ehte_pkg::REQ_LOOKUP, ehte_pkg::REQ_FIND, ehte_pkg::REQ_COUNT: begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN;
          end
          ehte_pkg::REQ_LEARN, ehte_pkg::REQ_UNLEARN: begin
            cmd.wr_en = 1'b1;
            state_nxt = S_FINISH;
          end
          ehte_pkg::REQ_CLEAR: begin
            cmd.clr_all = 1'b1;
            state_nxt   = S_FINISH;
          end
          ehte_pkg::REQ_READ: begin
            cmd.rd_en = 1'b1;
            state_nxt = S_FINISH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/ehte_dp.sv
module ehte_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [ehte_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [ehte_pkg::IN_USER_W-1:0]       in_tuser,
  input  ehte_pkg::ehte_cmd_t                  cmd,
  output ehte_pkg::ehte_sts_t                  sts,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ehte_pkg::OUT_DATA_W-1:0]      out_tdata
);

  // Request registers.
  logic [2:0]  req_r;
  logic [7:0]  hash_r;
  logic [7:0]  opc_r;
  logic [7:0]  idx_r;
  logic        idx_ok;

  // Table: {opcode, hash} per entry; a cleared valid bit reads as an empty entry.
  logic [15:0] mem [ehte_pkg::MAX_EVENTS];
  logic [ehte_pkg::MAX_EVENTS-1:0] valid_r;

  logic [ehte_pkg::IDX_W-1:0] cnt_r;
  logic [ehte_pkg::IDX_W-1:0] rd_addr;
  logic [15:0]                rd_data_r;
  logic                       rd_vld_r;
  logic [ehte_pkg::IDX_W-1:0] rd_tag_r;
  logic                       eval_r;

  logic [7:0] eff_hash;
  logic [7:0] eff_opc;
  logic       match;

  logic                       hit_r;
  logic [ehte_pkg::IDX_W-1:0] hit_idx_r;
  logic [ehte_pkg::CNT_W-1:0] tally_r;

  logic                       out_vld_r;
  logic [ehte_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [ehte_pkg::RES_W-1:0] res_index;
  logic                       res_found;
  logic [7:0]                 res_hash;
  logic [ehte_pkg::RES_W-1:0] res_count;

  assign idx_ok  = (idx_r < 8'(ehte_pkg::MAX_EVENTS));
  assign rd_addr = cmd.rd_scan ? cnt_r : idx_r[ehte_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_tuser;
      hash_r <= ehte_pkg::event_hash(in_tdata[15:0], in_tdata[31:16]);
      opc_r  <= in_tdata[39:32];
      idx_r  <= in_tdata[47:40];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && idx_ok && (req_r == ehte_pkg::REQ_LEARN)) begin
      mem[idx_r[ehte_pkg::IDX_W-1:0]] <= {opc_r, hash_r};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clr_all) begin
      valid_r <= '0;
    end else if (cmd.wr_en && idx_ok) begin
      valid_r[idx_r[ehte_pkg::IDX_W-1:0]] <= (req_r == ehte_pkg::REQ_LEARN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      eval_r <= cmd.rd_en && cmd.rd_scan;
      if (cmd.scan_clr) begin
        cnt_r <= '0;
      end else if (cmd.rd_en && cmd.rd_scan) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld_r <= valid_r[rd_addr];
      rd_tag_r <= rd_addr;
    end
  end

  assign eff_hash = rd_vld_r ? rd_data_r[7:0]  : 8'h00;
  assign eff_opc  = rd_vld_r ? rd_data_r[15:8] : ehte_pkg::OPC_EMPTY;

  always_comb begin
    case (req_r)
      ehte_pkg::REQ_LOOKUP:
        match = (eff_hash == hash_r) &&
                ((opc_r == ehte_pkg::OPC_WILDCARD) || (eff_opc == opc_r));
      ehte_pkg::REQ_FIND:
        match = (eff_hash == 8'h00);
      default:
        match = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      hit_r   <= 1'b0;
      tally_r <= '0;
    end else if (eval_r) begin
      if (match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_tag_r;
      end
      if (eff_hash != 8'h00) begin
        tally_r <= tally_r + 1'b1;
      end
    end
  end

  always_comb begin
    res_index = '0;
    res_found = 1'b0;
    res_hash  = '0;
    res_count = '0;
    case (req_r) inside
      ehte_pkg::REQ_LOOKUP, ehte_pkg::REQ_FIND: begin
        res_found = hit_r;
        res_index = hit_r ? ehte_pkg::RES_W'(hit_idx_r)
                          : ehte_pkg::RES_W'(ehte_pkg::MAX_EVENTS);
        if (req_r == ehte_pkg::REQ_LOOKUP) begin
          res_hash = hash_r;
        end
      end
      ehte_pkg::REQ_LEARN: begin
        res_hash = hash_r;
      end
      ehte_pkg::REQ_COUNT: begin
        res_count = ehte_pkg::RES_W'(tally_r);
      end
      ehte_pkg::REQ_READ: begin
        res_hash = (idx_ok && rd_vld_r) ? rd_data_r[7:0] : 8'h00;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r <= {1'b0, res_count, res_hash, res_found, res_index};
    end
  end

  assign out_tvalid    = out_vld_r;
  assign out_tdata     = out_data_r;
  assign sts.req       = req_r;
  assign sts.scan_last = (cnt_r == ehte_pkg::IDX_W'(ehte_pkg::MAX_EVENTS - 1));
  assign sts.out_free  = !out_vld_r || out_tready;

endmodule

// File: sv/event_hash_table_engine.sv
// Channel  Direction  Ports                        Payload
// in_      slave      in_tvalid/in_tready          in_tdata (48 bits), in_tuser (3 bits)
// out_     master     out_tvalid/out_tready        out_tdata (24 bits)
//
// Lookup, find-empty and count scan the whole table between one input transfer
// and the next: the scan reads one table entry per cycle from a single memory port.
// Learn, unlearn, clear-all and read-entry need no scan and go from decode straight to the result.
// Reset (rst_n low, synchronous) empties the table at once through per-entry
// valid bits; no clearing pass is needed.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only its own result waits for the output to drain.
module event_hash_table_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] event_node, [31:16] event_number, [39:32] event_opcode,
  // [47:40] entry_index
  input  logic [47:0] in_tdata,
  // [2:0] req_type
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [6:0] result_index, [7] found, [15:8] entry_hash, [22:16] event_count,
  // [23] zero
  output logic [23:0] out_tdata
);

  // The controller sequences each request; the datapath holds the table, the
  // hash unit, the scan counter with its compare stage and the output register.
  ehte_pkg::ehte_cmd_t cmd;
  ehte_pkg::ehte_sts_t sts;

  ehte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ehte_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: sv/ehte_checker.sv
`include "event_hash_table_engine_defines.svh"

module ehte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  logic [6:0] res_index;
  logic       res_found;
  logic [6:0] res_count;
  logic [6:0] table_size;

  assign res_index  = out_tdata[6:0];
  assign res_found  = out_tdata[7];
  assign res_count  = out_tdata[22:16];
  assign table_size = 7'(ehte_pkg::MAX_EVENTS);

  // One request at a time: the input closes right after a transfer.
  `EHTE_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

  // A result held back by the sink stays unchanged.
  `EHTE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // A found index lies inside the table.
  `EHTE_ASSERT_NOW(a_found_in_range, out_tvalid && res_found, res_index < table_size)

  // Without a find, a nonzero index can only be the not-found marker.
  `EHTE_ASSERT_NOW(a_miss_marker, out_tvalid && !res_found && |res_index, res_index == table_size)

  // The count never exceeds the table size.
  `EHTE_ASSERT_NOW(a_count_range, out_tvalid, res_count <= table_size)

endmodule

bind event_hash_table_engine ehte_checker u_ehte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
